// ===== rtl/core/prmc_pkg.sv =====
// Shared types and constants of the point region mask classifier.
`default_nettype none
package prmc_pkg;

  localparam int MAX_MASKS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_BITS       = 5;
  localparam int SLOT_BITS      = 4;

  // Multiplies per product chain (six narrow factors), chain indexes
  localparam logic [2:0] LAST_STEP = 3'd5;
  localparam logic [1:0] LIM_CHAIN = 2'd3;

  typedef enum logic [1:0] {
    KIND_NO_MASKS = 2'd0,
    KIND_NO_HIT   = 2'd1,
    KIND_HIT      = 2'd2,
    KIND_HALT     = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ELL_INIT,
    ST_ELL_MUL,
    ST_ELL_DRAIN,
    ST_ELL_COMMIT,
    ST_ELL_CHAIN,
    ST_RESULT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic       wr;         // write the mask table
    logic       cap_pt;     // capture point minus origin
    logic       rd;         // read one mask slot
    logic       start_ell;  // capture offsets, clear sum
    logic       chain_init; // load first factor of a chain
    logic       issue;      // multiply one limb
    logic       commit;     // product becomes the running operand
    logic       sum_add;    // add finished chain into sum
    logic [1:0] chain;
    logic [2:0] step;
    logic [2:0] limb;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_box;
    logic incl;
    logic box_hit;
    logic degen;
    logic ell_in;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/prmc_datapath.sv =====
// Datapath: mask table, point registers, box compare and limb multiply unit.
`default_nettype none
module prmc_datapath #(
  parameter int MAX_MASKS  = prmc_pkg::MAX_MASKS_DEF,
  parameter int COORD_BITS = prmc_pkg::COORD_BITS_DEF,
  localparam int SW = (MAX_MASKS > 1) ? $clog2(MAX_MASKS) : 1
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  prmc_pkg::dp_cmd_t                cmd_i,
  input  wire [SW-1:0]                     rd_addr_i,
  input  wire [prmc_pkg::SLOT_BITS-1:0]    slot_i,
  input  wire                              include_region_i,
  input  wire                              box_shape_i,
  input  wire signed [COORD_BITS-1:0]      coord_x_i,
  input  wire signed [COORD_BITS-1:0]      coord_y_i,
  input  wire signed [COORD_BITS-1:0]      coord_z_i,
  input  wire signed [COORD_BITS-1:0]      aux_x_i,
  input  wire signed [COORD_BITS-1:0]      aux_y_i,
  input  wire signed [COORD_BITS-1:0]      aux_z_i,
  output prmc_pkg::dp_status_t             status_o
);
  import prmc_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int N  = C + 2;       // limb and factor width
  localparam int AW = 6 * N;       // full chain product width
  localparam int EW = 2 + 6 * C;   // table entry: flags, centre, half-axes

  // Mask table
  logic [EW-1:0] mem_q [MAX_MASKS];
  logic [EW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (32'(slot_i) < MAX_MASKS)) begin
      mem_q[SW'(slot_i)] <= {aux_z_i, aux_y_i, aux_x_i, coord_z_i, coord_y_i, coord_x_i,
                             box_shape_i, include_region_i};
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  logic signed [C-1:0] mc [3];
  logic signed [C-1:0] mr [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mc[i] = rd_q[2 + i*C +: C];
      mr[i] = rd_q[2 + (3+i)*C +: C];
    end
  end

  // Point relative to origin
  logic signed [C:0] p_q [3];
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_pt) begin
      p_q[0] <= {coord_x_i[C-1], coord_x_i} - {aux_x_i[C-1], aux_x_i};
      p_q[1] <= {coord_y_i[C-1], coord_y_i} - {aux_y_i[C-1], aux_y_i};
      p_q[2] <= {coord_z_i[C-1], coord_z_i} - {aux_z_i[C-1], aux_z_i};
    end
  end

  // Box test and degenerate radius check
  logic signed [C:0]   lo [3];
  logic signed [C:0]   hi [3];
  logic signed [C+1:0] dd [3];
  logic [N-1:0]        d_abs [3];
  logic [N-1:0]        r_u [3];
  logic                box_hit, degen;
  always_comb begin
    box_hit = 1'b1;
    degen   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lo[i] = {mc[i][C-1], mc[i]} - {mr[i][C-1], mr[i]};
      hi[i] = {mc[i][C-1], mc[i]} + {mr[i][C-1], mr[i]};
      if ((p_q[i] < lo[i]) || (p_q[i] > hi[i])) begin
        box_hit = 1'b0;
      end
      if (mr[i][C-1] || (mr[i] == '0)) begin
        degen = 1'b1;
      end
      dd[i]    = {p_q[i][C], p_q[i]} - {{2{mc[i][C-1]}}, mc[i]};
      d_abs[i] = dd[i][C+1] ? N'(-dd[i]) : N'(dd[i]);
      r_u[i]   = {2'b00, mr[i]};
    end
  end

  // Factor for a given chain and step: d_i^2 r_j^2 r_k^2, last chain r0^2 r1^2 r2^2
  logic [N-1:0] d_q [3];

  function automatic logic [N-1:0] pick(input logic [1:0] ch, input logic [2:0] st,
                                        input logic [N-1:0] d0, input logic [N-1:0] d1,
                                        input logic [N-1:0] d2, input logic [N-1:0] r0,
                                        input logic [N-1:0] r1, input logic [N-1:0] r2);
    logic [1:0]   grp;
    logic [N-1:0] f;
    grp = 2'(st >> 1);
    f   = r0;
    case (ch)
      2'd0:    f = (grp == 2'd0) ? d0 : ((grp == 2'd1) ? r1 : r2);
      2'd1:    f = (grp == 2'd0) ? d1 : ((grp == 2'd1) ? r2 : r0);
      2'd2:    f = (grp == 2'd0) ? d2 : ((grp == 2'd1) ? r0 : r1);
      default: f = (grp == 2'd0) ? r0 : ((grp == 2'd1) ? r1 : r2);
    endcase
    return f;
  endfunction

  logic [N-1:0] factor;
  assign factor = pick(cmd_i.chain, cmd_i.step, d_q[0], d_q[1], d_q[2],
                       r_u[0], r_u[1], r_u[2]);

  // Limb multiplier, registered product, accumulated in the following cycle
  logic [AW-1:0]  a_q, acc_q, sum_q;
  logic [2*N-1:0] mul_q;
  logic [2:0]     sh_q;
  logic           mul_vld_q;
  logic [N-1:0]   limb;

  assign limb = a_q[cmd_i.limb*N +: N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_ell) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= d_abs[i];
      end
      sum_q <= '0;
    end
    if (cmd_i.issue) begin
      mul_q <= limb * factor;
      sh_q  <= cmd_i.limb;
    end
    if (cmd_i.chain_init) begin
      a_q   <= AW'(factor);
      acc_q <= '0;
    end else if (cmd_i.commit) begin
      a_q   <= acc_q;
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + (AW'(mul_q) << (sh_q * N));
    end
    if (cmd_i.sum_add) begin
      sum_q <= sum_q + a_q;
    end
  end

  assign status_o.is_box  = rd_q[1];
  assign status_o.incl    = rd_q[0];
  assign status_o.box_hit = box_hit;
  assign status_o.degen   = degen;
  assign status_o.ell_in  = (sum_q <= a_q);

endmodule
`default_nettype wire

// ===== rtl/core/prmc_ctrl.sv =====
// Controller: handshakes, mask count register, slot walk and multiply sequencing.
`default_nettype none
module prmc_ctrl #(
  parameter int MAX_MASKS = prmc_pkg::MAX_MASKS_DEF,
  localparam int SW = (MAX_MASKS > 1) ? $clog2(MAX_MASKS) : 1
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              mode_i,
  input  wire                              out_ready_i,
  output logic                             out_valid_o,
  output logic                             inside_res_o,
  output logic [1:0]                       decision_kind_o,
  output logic [prmc_pkg::SLOT_BITS-1:0]   deciding_slot_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [prmc_pkg::CFG_BITS-1:0]    cfg_data_i,
  output prmc_pkg::dp_cmd_t                cmd_o,
  output logic [SW-1:0]                    rd_addr_o,
  input  prmc_pkg::dp_status_t             status_i
);
  import prmc_pkg::*;

  state_e                 state_q, state_d;
  logic [SW-1:0]          s_q, s_d;
  logic [1:0]             c_q, c_d;
  logic [2:0]             t_q, t_d, k_q, k_d;
  logic [CFG_BITS-1:0]    cnt_q;
  logic                   pin_q, pin_d;
  kind_e                  pkind_q, pkind_d;
  logic [SLOT_BITS-1:0]   pslot_q, pslot_d;
  logic                   ovld_q, ovld_d, oin_q;
  kind_e                  okind_q;
  logic [SLOT_BITS-1:0]   oslot_q;
  logic                   res_load;
  logic [8:0]             n_used;

  // Slots in use, clipped to the table depth
  assign n_used = (32'(cnt_q) > MAX_MASKS) ? 9'(MAX_MASKS) : 9'(cnt_q);

  assign cfg_ready_o     = 1'b1;
  assign rd_addr_o       = s_q;
  assign out_valid_o     = ovld_q;
  assign inside_res_o    = oin_q;
  assign decision_kind_o = okind_q;
  assign deciding_slot_o = oslot_q;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    s_d        = s_q;
    c_d        = c_q;
    t_d        = t_q;
    k_d        = k_q;
    pin_d      = pin_q;
    pkind_d    = pkind_q;
    pslot_d    = pslot_q;
    cmd_o      = '0;
    cmd_o.chain = c_q;
    cmd_o.step  = t_q;
    cmd_o.limb  = k_q;
    in_ready_o = 1'b0;
    res_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!mode_i) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.cap_pt = 1'b1;
            if (n_used == '0) begin
              pin_d   = 1'b1;
              pkind_d = KIND_NO_MASKS;
              pslot_d = '0;
              state_d = ST_RESULT;
            end else begin
              s_d     = SW'(n_used - 9'd1);
              state_d = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.is_box) begin
          if (status_i.box_hit) begin
            pin_d   = status_i.incl;
            pkind_d = KIND_HIT;
            pslot_d = SLOT_BITS'(s_q);
            state_d = ST_RESULT;
          end else if (s_q == '0) begin
            pin_d   = 1'b0;
            pkind_d = KIND_NO_HIT;
            pslot_d = '0;
            state_d = ST_RESULT;
          end else begin
            s_d     = s_q - 1'b1;
            state_d = ST_READ;
          end
        end else if (status_i.degen) begin
          pin_d   = 1'b0;
          pkind_d = KIND_HALT;
          pslot_d = SLOT_BITS'(s_q);
          state_d = ST_RESULT;
        end else begin
          cmd_o.start_ell = 1'b1;
          c_d     = '0;
          state_d = ST_ELL_INIT;
        end
      end
      ST_ELL_INIT: begin
        cmd_o.chain_init = 1'b1;
        cmd_o.step       = '0;
        t_d     = 3'd1;
        k_d     = '0;
        state_d = ST_ELL_MUL;
      end
      ST_ELL_MUL: begin
        cmd_o.issue = 1'b1;
        if (k_q == t_q - 3'd1) begin
          state_d = ST_ELL_DRAIN;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      ST_ELL_DRAIN: begin
        state_d = ST_ELL_COMMIT;
      end
      ST_ELL_COMMIT: begin
        cmd_o.commit = 1'b1;
        k_d = '0;
        if (t_q == LAST_STEP) begin
          state_d = ST_ELL_CHAIN;
        end else begin
          t_d     = t_q + 3'd1;
          state_d = ST_ELL_MUL;
        end
      end
      ST_ELL_CHAIN: begin
        if (c_q != LIM_CHAIN) begin
          cmd_o.sum_add = 1'b1;
          c_d     = c_q + 2'd1;
          state_d = ST_ELL_INIT;
        end else if (status_i.ell_in) begin
          pin_d   = status_i.incl;
          pkind_d = KIND_HIT;
          pslot_d = SLOT_BITS'(s_q);
          state_d = ST_RESULT;
        end else if (s_q == '0) begin
          pin_d   = 1'b0;
          pkind_d = KIND_NO_HIT;
          pslot_d = '0;
          state_d = ST_RESULT;
        end else begin
          s_d     = s_q - 1'b1;
          state_d = ST_READ;
        end
      end
      ST_RESULT: begin
        if (!ovld_q || out_ready_i) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ovld_d = res_load | (ovld_q & ~out_ready_i);

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
      s_q     <= '0;
      c_q     <= '0;
      t_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      s_q     <= s_d;
      c_q     <= c_d;
      t_q     <= t_d;
      k_q     <= k_d;
      if (cfg_valid_i) begin
        cnt_q <= cfg_data_i;
      end
    end
  end

  // Pending and output payload
  always_ff @(posedge clk_i) begin
    pin_q   <= pin_d;
    pkind_q <= pkind_d;
    pslot_q <= pslot_d;
    if (res_load) begin
      oin_q   <= pin_q;
      okind_q <= pkind_q;
      oslot_q <= pslot_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/point_region_mask_classifier_unit.sv =====
// Top level of the point region mask classifier.
//
// Input channel (in_valid_i/in_ready_o): mode 0 loads one mask slot (box or
// ellipsoid, include or hole) and returns nothing; mode 1 classifies a point
// minus an origin and returns one result transaction on the output channel.
// Config channel (cfg_valid_i/cfg_ready_o) sets mask_count, slots searched
// from mask_count-1 (clipped to the table depth) down; write it only while the unit is idle.
// A load is written from the idle state, which the unit stays in. A query
// reads and evaluates each slot visited, runs four product chains for each
// non-degenerate ellipsoid slot, then moves its result to the output register.
// One shared (C+2)x(C+2) multiplier builds the six-factor chains limb by limb.
// A new transaction is taken as soon as the previous query has reached the
// output register, even if that result is still waiting.
// Reset clears the count to zero and empties the output; the mask table is
// not cleared. A stalled receiver holds the result and, once a second query
// finishes, the unit waits until the first is taken.
`default_nettype none
module point_region_mask_classifier_unit #(
  parameter int MAX_MASKS  = prmc_pkg::MAX_MASKS_DEF,
  parameter int COORD_BITS = prmc_pkg::COORD_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              mode_i,
  input  wire  [prmc_pkg::SLOT_BITS-1:0]   slot_i,
  input  wire                              include_region_i,
  input  wire                              box_shape_i,
  input  wire signed [COORD_BITS-1:0]      coord_x_i,
  input  wire signed [COORD_BITS-1:0]      coord_y_i,
  input  wire signed [COORD_BITS-1:0]      coord_z_i,
  input  wire signed [COORD_BITS-1:0]      aux_x_i,
  input  wire signed [COORD_BITS-1:0]      aux_y_i,
  input  wire signed [COORD_BITS-1:0]      aux_z_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             inside_res_o,
  output logic [1:0]                       decision_kind_o,
  output logic [prmc_pkg::SLOT_BITS-1:0]   deciding_slot_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [prmc_pkg::CFG_BITS-1:0]    cfg_data_i
);
  import prmc_pkg::*;

  localparam int SW = (MAX_MASKS > 1) ? $clog2(MAX_MASKS) : 1;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [SW-1:0] rd_addr;

  prmc_ctrl #(
    .MAX_MASKS (MAX_MASKS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .inside_res_o    (inside_res_o),
    .decision_kind_o (decision_kind_o),
    .deciding_slot_o (deciding_slot_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .cmd_o           (cmd),
    .rd_addr_o       (rd_addr),
    .status_i        (status)
  );

  prmc_datapath #(
    .MAX_MASKS  (MAX_MASKS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .slot_i           (slot_i),
    .include_region_i (include_region_i),
    .box_shape_i      (box_shape_i),
    .coord_x_i        (coord_x_i),
    .coord_y_i        (coord_y_i),
    .coord_z_i        (coord_z_i),
    .aux_x_i          (aux_x_i),
    .aux_y_i          (aux_y_i),
    .aux_z_i          (aux_z_i),
    .status_o         (status)
  );

endmodule
`default_nettype wire

// ===== tb/point_region_mask_classifier_unit_test.sv =====
// Testbench of the point region mask classifier: directed and random loads and queries.
`default_nettype none
module point_region_mask_classifier_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import prmc_pkg::*;

  localparam int NSLOT = 16;
  localparam bit MODE_LOAD = 1'b0;
  localparam bit MODE_QUERY = 1'b1;

  typedef struct {
    bit                 mode;
    logic [3:0]         slot;
    bit                 incl;
    bit                 box;
    logic signed [15:0] c [3];
    logic signed [15:0] a [3];
  } region_item_t;

  typedef struct {
    bit         in_res;
    kind_e      kind;
    logic [3:0] slot;
  } region_res_t;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  // Block inputs, known from time zero
  logic         in_valid = 1'b0;
  logic         out_ready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic [4:0]   cfg_data = '0;
  region_item_t in_item = '{mode: 1'b0, slot: '0, incl: 1'b0, box: 1'b0,
                            c: '{default: '0}, a: '{default: '0}};
  logic         in_ready, out_valid, cfg_ready, inside_res;
  logic [1:0]   decision_kind;
  logic [3:0]   deciding_slot;

  point_region_mask_classifier_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(in_item.mode), .slot_i(in_item.slot),
    .include_region_i(in_item.incl), .box_shape_i(in_item.box),
    .coord_x_i(in_item.c[0]), .coord_y_i(in_item.c[1]), .coord_z_i(in_item.c[2]),
    .aux_x_i(in_item.a[0]), .aux_y_i(in_item.a[1]), .aux_z_i(in_item.a[2]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .inside_res_o(inside_res), .decision_kind_o(decision_kind),
    .deciding_slot_o(deciding_slot),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  // Shadow mask table and count, updated on accepted transactions
  logic [1:0] mask_kind_q [NSLOT];   // bit0 include, bit1 box
  int         mask_ctr_q  [NSLOT][3];
  int         mask_rad_q  [NSLOT][3];
  logic [4:0] mask_count_q = '0;

  // Table as seen by the generator, ahead of acceptance
  int         gen_ctr [NSLOT][3];
  int         gen_rad [NSLOT][3];

  region_item_t pending_items [$];
  region_res_t  expected_results [$];
  bit  calm = 1'b0;
  bit  in_took = 1'b0;
  int  in_gap = 0;
  int  out_hold = 0;
  int  errors = 0;
  int  n_loads = 0, n_queries = 0;
  int  kind_seen [4] = '{0, 0, 0, 0};

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // Search the mask table from the top slot down
  function automatic region_res_t classify_point(region_item_t it);
    region_res_t r;
    int          p [3];
    longint      dd;
    logic [191:0] dsq [3];
    logic [191:0] rsq [3];
    logic [191:0] acc, lim;
    int          n;
    bit          hit;
    n = (mask_count_q > NSLOT) ? NSLOT : int'(mask_count_q);
    r = '{in_res: 1'b1, kind: KIND_NO_MASKS, slot: '0};
    if (n == 0) return r;
    r = '{in_res: 1'b0, kind: KIND_NO_HIT, slot: '0};
    for (int i = 0; i < 3; i++) p[i] = int'(it.c[i]) - int'(it.a[i]);
    for (int s = n - 1; s >= 0; s--) begin
      if (mask_kind_q[s][1]) begin
        hit = 1'b1;
        for (int i = 0; i < 3; i++)
          if (p[i] < mask_ctr_q[s][i] - mask_rad_q[s][i] ||
              p[i] > mask_ctr_q[s][i] + mask_rad_q[s][i]) hit = 1'b0;
      end else begin
        if (mask_rad_q[s][0] <= 0 || mask_rad_q[s][1] <= 0 || mask_rad_q[s][2] <= 0) begin
          r = '{in_res: 1'b0, kind: KIND_HALT, slot: 4'(s)};
          return r;
        end
        for (int i = 0; i < 3; i++) begin
          dd = longint'(p[i] - mask_ctr_q[s][i]);
          dsq[i] = 192'(dd * dd);
          dd = longint'(mask_rad_q[s][i]);
          rsq[i] = 192'(dd * dd);
        end
        // exact cross-multiplied ellipsoid test
        acc = dsq[0] * rsq[1] * rsq[2] + dsq[1] * rsq[0] * rsq[2] + dsq[2] * rsq[0] * rsq[1];
        lim = rsq[0] * rsq[1] * rsq[2];
        hit = (acc <= lim);
      end
      if (hit) begin
        r = '{in_res: mask_kind_q[s][0], kind: KIND_HIT, slot: 4'(s)};
        return r;
      end
    end
    return r;
  endfunction

  // Input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_gap <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Input acceptance: update table or predict the result
  always @(posedge clk_i) begin
    in_took <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      if (in_item.mode == MODE_LOAD) begin
        mask_kind_q[in_item.slot] = {in_item.box, in_item.incl};
        for (int i = 0; i < 3; i++) begin
          mask_ctr_q[in_item.slot][i] = int'(in_item.c[i]);
          mask_rad_q[in_item.slot][i] = int'(in_item.a[i]);
        end
        n_loads++;
      end else begin
        expected_results.push_back(classify_point(in_item));
        n_queries++;
      end
    end
  end

  // Output ready with random stalls
  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_ready <= rst_ni;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      out_hold <= draw_wait();
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result inside=%0d kind=%0d slot=%0d",
                 $time, inside_res, decision_kind, deciding_slot);
        errors++;
      end else begin
        region_res_t e;
        e = expected_results.pop_front();
        kind_seen[e.kind]++;
        if (inside_res !== e.in_res) begin
          $display("%0t: inside_res expected %0d actual %0d", $time, e.in_res, inside_res);
          errors++;
        end
        if (decision_kind !== e.kind) begin
          $display("%0t: decision_kind expected %0d actual %0d", $time, e.kind, decision_kind);
          errors++;
        end
        if (deciding_slot !== e.slot) begin
          $display("%0t: deciding_slot expected %0d actual %0d", $time, e.slot, deciding_slot);
          errors++;
        end
      end
    end
  end

  task automatic push_load(int slot, bit incl, bit box, int cx, int cy, int cz,
                           int rx, int ry, int rz);
    region_item_t it;
    it.mode = MODE_LOAD; it.slot = 4'(slot); it.incl = incl; it.box = box;
    it.c[0] = 16'(cx); it.c[1] = 16'(cy); it.c[2] = 16'(cz);
    it.a[0] = 16'(rx); it.a[1] = 16'(ry); it.a[2] = 16'(rz);
    for (int i = 0; i < 3; i++) begin
      gen_ctr[slot][i] = int'(it.c[i]);
      gen_rad[slot][i] = int'(it.a[i]);
    end
    pending_items.push_back(it);
  endtask

  task automatic push_query(int px, int py, int pz, int ox, int oy, int oz);
    region_item_t it;
    it.mode = MODE_QUERY; it.slot = 4'($urandom); it.incl = 1'($urandom);
    it.box = 1'($urandom);
    it.c[0] = 16'(px); it.c[1] = 16'(py); it.c[2] = 16'(pz);
    it.a[0] = 16'(ox); it.a[1] = 16'(oy); it.a[2] = 16'(oz);
    pending_items.push_back(it);
  endtask

  // Wait for all traffic to drain, plus slack for a trailing load
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_count(int v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= 5'(v);
    do @(posedge clk_i); while (!cfg_ready);
    mask_count_q = 5'(v);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Random mask, mostly boxes and modest ellipsoids
  task automatic random_load(int slot);
    int r [3];
    bit box;
    box = ($urandom_range(0, 9) < 6);
    for (int i = 0; i < 3; i++) begin
      if (box) r[i] = ($urandom_range(0, 9) == 0) ? -$urandom_range(1, 50)
                                                  : $urandom_range(0, 3000);
      else r[i] = $urandom_range(1, 3000);
    end
    if (!box && $urandom_range(0, 9) == 0) r[$urandom_range(0, 2)] = -$urandom_range(0, 5);
    push_load(slot, 1'($urandom), box, $urandom_range(0, 16000) - 8000,
              $urandom_range(0, 16000) - 8000, $urandom_range(0, 16000) - 8000,
              r[0], r[1], r[2]);
  endtask

  // Query aimed near a loaded mask, offset by a random origin
  task automatic aimed_query();
    int s, o [3], p [3], span;
    s = $urandom_range(0, NSLOT - 1);
    for (int i = 0; i < 3; i++) begin
      span = (gen_rad[s][i] < 0 ? -gen_rad[s][i] : gen_rad[s][i]) * 5 / 4 + 2;
      o[i] = $urandom_range(0, 8000) - 4000;
      p[i] = gen_ctr[s][i] + $urandom_range(0, 2 * span) - span + o[i];
    end
    push_query(p[0], p[1], p[2], o[0], o[1], o[2]);
  endtask

  // Stimulus
  initial begin
    int counts [6] = '{16, 17, 31, 1, 8, 0};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // No masks: extreme points and origins
    push_query(32767, -32768, 0, -32768, 32767, 0);
    push_query(-32768, 32767, -1, 32767, -32768, -1);
    // Fill every slot before any search can reach it
    for (int s = 0; s < NSLOT; s++)
      push_load(s, s[0], 1'b1, 0, 0, 0, -1, -1, -1);      // empty boxes
    push_load(15, 1'b1, 1'b0, 0, 0, 0, 100, 200, 300);     // include ellipsoid
    push_load(14, 1'b0, 1'b1, 1000, 1000, 1000, 10, 10, 10); // hole box
    push_load(3, 1'b0, 1'b0, 0, 0, 0, 5, 0, 5);            // degenerate ellipsoid
    push_load(0, 1'b1, 1'b1, 0, 0, 0, 32767, 32767, 32767);  // include box, +-32767 around zero
    drain();
    write_count(16);
    push_query(100, 0, 0, 0, 0, 0);        // ellipsoid edge, hit
    push_query(101, 0, 0, 0, 0, 0);        // just outside, falls to degenerate
    push_query(1010, 990, 1000, 0, 0, 0);  // hole box corner
    push_query(32767, 32767, 32767, -32768, -32768, -32768);
    drain();
    write_count(2);
    push_query(-32768, -32768, -32768, 32767, 32767, 32767);
    push_query(5, 5, 5, 5, 5, 5);
    drain();
    write_count(31);                       // acts as sixteen
    push_query(0, 0, 300, 0, 0, 0);
    drain();

    // Random phases
    for (int ph = 0; ph < 30; ph++) begin
      calm = (ph % 5 == 2);
      if (ph < 6) write_count(counts[ph]);
      else write_count($urandom_range(0, 9) == 0 ? $urandom_range(17, 31)
                                                 : $urandom_range(0, 16));
      for (int k = 0; k < 60; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: random_load($urandom_range(0, NSLOT - 1));
          4: push_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          5: push_load($urandom_range(0, NSLOT - 1), 1'($urandom), 1'($urandom), $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom);
          default: aimed_query();
        endcase
      end
      drain();
    end

    $display("Ran %0d loads and %0d queries across 30 random count settings.",
             n_loads, n_queries);
    $display("Decisions: %0d no masks, %0d no hit, %0d hit, %0d halted.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (errors == 0) begin
      $display("point_region_mask_classifier_unit_test passed");
    end else begin
      $display("point_region_mask_classifier_unit_test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("point_region_mask_classifier_unit_test failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== point_region_mask_classifier_unit.f =====
rtl/core/prmc_pkg.sv
rtl/core/prmc_datapath.sv
rtl/core/prmc_ctrl.sv
rtl/core/point_region_mask_classifier_unit.sv
tb/point_region_mask_classifier_unit_test.sv
